// ===== rtl/packet_sequence_gap_tracker_top_defines.svh =====
// ----------------------------------------------------------------------------
// packet sequence gap tracker assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_GAP_TRACKER_TOP_DEFINES_SVH
`define PACKET_SEQUENCE_GAP_TRACKER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define PSGT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define PSGT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/psgt_pkg.sv =====
// ----------------------------------------------------------------------------
// psgt_pkg
// widths, register codes, reset values and control types of the gap tracker
// ----------------------------------------------------------------------------
`default_nettype none

package psgt_pkg;

   // field widths
   localparam int SEQ_W      = 12;
   localparam int LEN_W      = 16;
   localparam int PB_W       = 16;
   localparam int PT_W       = 13;
   localparam int NE_W       = 13;
   localparam int CNT_W      = 13;
   localparam int BT_W       = 32;
   localparam int OFF_W      = 28;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // default map size
   localparam int MAX_PACKETS_DEF = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_BYTES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_TOTAL = CSR_IDX_W'(1);

   // register reset values
   localparam logic [PB_W-1:0] PB_RESET = PB_W'(1024);
   localparam logic [PT_W-1:0] PT_RESET = PT_W'(4096);

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic lookup;
      logic mark;
      logic emit;
   } psgt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic ahead;
      logic walk_last;
      logic slot_free;
   } psgt_status_type;

   // ids that can ever be tracked: bounded by the map size and the id field
   function automatic int psgt_map_depth(input int max_packets);
      int lim;
      lim = 1 << SEQ_W;
      return (max_packets < lim) ? max_packets : lim;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/psgt_if.sv =====
// ----------------------------------------------------------------------------
// psgt channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

// packet report channel
interface psgt_req_if import psgt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_id;
   logic [LEN_W-1:0] payload_len;

   modport source (output valid, seq_id, payload_len, input ready);
   modport sink   (input valid, seq_id, payload_len, output ready);
endinterface

// result channel
interface psgt_rsp_if import psgt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OFF_W-1:0] write_offset;
   logic [BT_W-1:0]  bytes_received;
   logic             size_error;
   logic             gap_filled;
   logic             transfer_done;

   modport source (output valid, write_offset, bytes_received, size_error,
                   gap_filled, transfer_done, input ready);
   modport sink   (input valid, write_offset, bytes_received, size_error,
                   gap_filled, transfer_done, output ready);
endinterface

// register write channel
interface psgt_csr_if import psgt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/psgt_ram.sv =====
// ----------------------------------------------------------------------------
// psgt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module psgt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/psgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// psgt_ctrl
// sequencer for lookup, gap marking and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module psgt_ctrl import psgt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  psgt_status_type status,
   output psgt_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_MARK   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = status.ahead ? ST_MARK : ST_EMIT;
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (status.walk_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit  = 1'b1;
               req_ready = 1'b1;
               // take the next transaction in the same cycle
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_LOOKUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psgt_dp.sv =====
// ----------------------------------------------------------------------------
// psgt_dp
// tracker state, missing map, byte total, offset multiply and result register
// ----------------------------------------------------------------------------
`default_nettype none

module psgt_dp import psgt_pkg::*; #(
   parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psgt_cmd_type          cmd,
   output psgt_status_type       status,
   input  logic [SEQ_W-1:0]      req_seq_id,
   input  logic [LEN_W-1:0]      req_payload_len,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [OFF_W-1:0]      rsp_write_offset,
   output logic [BT_W-1:0]       rsp_bytes_received,
   output logic                  rsp_size_error,
   output logic                  rsp_gap_filled,
   output logic                  rsp_transfer_done
);

   localparam int MAP_DEPTH = psgt_map_depth(MAX_PACKETS);
   localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam logic [NE_W-1:0] MAP_LIMIT = NE_W'(MAP_DEPTH);

   // configuration
   logic [PB_W-1:0]  pb_ff;
   logic [PT_W-1:0]  pt_ff;

   // captured transaction
   logic [SEQ_W-1:0] seq_ff;
   logic [LEN_W-1:0] len_ff;

   // tracker state
   logic [NE_W-1:0]  ne_ff,   ne_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [BT_W-1:0]  bt_ff,   bt_in;
   logic [NE_W-1:0]  walk_ff, walk_in;

   // per-item results
   logic [OFF_W-1:0] offset_ff,   offset_in;
   logic             size_err_ff, size_err_in;
   logic             filled_ff,   filled_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0] out_offset_ff;
   logic [BT_W-1:0]  out_bt_ff;
   logic             out_err_ff;
   logic             out_fill_ff;
   logic             out_done_ff;

   // map port
   logic             map_wr_en;
   logic [AW-1:0]    map_wr_addr;
   logic [0:0]       map_wr_data;
   logic [0:0]       map_rd_data;

   // derived
   logic [NE_W-1:0]        seq_ext;
   logic [NE_W-1:0]        ne_plus;
   logic                   seq_in_map;
   logic                   walk_in_map;
   logic                   seq_seen;
   logic                   ahead;
   logic                   equal;
   logic                   filled_now;
   logic [BT_W:0]          bt_sum;
   logic [BT_W-1:0]        bt_sat;
   logic [PB_W+SEQ_W-1:0]  product;

   // an entry below next_expected has always been written, so the map needs
   // no clearing: entries at or above it read as not missing
   psgt_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_seq_id[AW-1:0]),
      .rd_data (map_rd_data)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff <= PB_RESET;
         pt_ff <= PT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PACKET_BYTES: pb_ff <= csr_data[PB_W-1:0];
            CSR_PACKET_TOTAL: pt_ff <= csr_data[PT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // compare and arithmetic on the captured transaction
   assign seq_ext     = NE_W'(seq_ff);
   assign ne_plus     = ne_ff + NE_W'(1);
   assign seq_in_map  = seq_ext < MAP_LIMIT;
   assign walk_in_map = walk_ff < MAP_LIMIT;
   assign seq_seen    = seq_ext < ne_ff;
   assign ahead       = seq_ext > ne_ff;
   assign equal       = seq_ext == ne_ff;
   assign filled_now  = map_rd_data[0] & seq_seen & seq_in_map;
   assign bt_sum      = {1'b0, bt_ff} + (BT_W+1)'(len_ff);
   assign bt_sat      = bt_sum[BT_W] ? '1 : bt_sum[BT_W-1:0];
   assign product     = pb_ff * seq_ff;

   // map writes: clear the arriving id, then set each skipped id
   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = seq_ff[AW-1:0];
      map_wr_data = 1'b0;
      if (cmd.lookup) begin
         map_wr_en = seq_in_map;
      end else if (cmd.mark) begin
         map_wr_en   = walk_in_map;
         map_wr_addr = walk_ff[AW-1:0];
         map_wr_data = 1'b1;
      end
   end

   // tracker state update
   always_comb begin
      ne_in       = ne_ff;
      cnt_in      = cnt_ff;
      bt_in       = bt_ff;
      walk_in     = walk_ff;
      offset_in   = offset_ff;
      size_err_in = size_err_ff;
      filled_in   = filled_ff;
      if (cmd.lookup) begin
         cnt_in      = cnt_ff - CNT_W'(filled_now);
         bt_in       = bt_sat;
         walk_in     = ne_ff;
         offset_in   = OFF_W'(product);
         filled_in   = filled_now;
         size_err_in = equal && (len_ff != pb_ff) && (ne_plus != pt_ff);
         if (ahead) begin
            ne_in = seq_ext + NE_W'(1);
         end else if (equal) begin
            ne_in = ne_plus;
         end
      end else if (cmd.mark) begin
         walk_in = walk_ff + NE_W'(1);
         cnt_in  = cnt_ff + CNT_W'(walk_in_map);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff  <= '0;
         cnt_ff <= '0;
         bt_ff  <= '0;
      end else begin
         ne_ff  <= ne_in;
         cnt_ff <= cnt_in;
         bt_ff  <= bt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff <= req_seq_id;
         len_ff <= req_payload_len;
      end
      walk_ff     <= walk_in;
      offset_ff   <= offset_in;
      size_err_ff <= size_err_in;
      filled_ff   <= filled_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_offset_ff <= offset_ff;
         out_bt_ff     <= bt_ff;
         out_err_ff    <= size_err_ff;
         out_fill_ff   <= filled_ff;
         out_done_ff   <= (ne_ff == pt_ff) && (cnt_ff == '0);
      end
   end

   // status to controller
   assign status.ahead     = ahead;
   assign status.walk_last = (walk_ff + NE_W'(1)) == seq_ext;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_offset   = out_offset_ff;
   assign rsp_bytes_received = out_bt_ff;
   assign rsp_size_error     = out_err_ff;
   assign rsp_gap_filled     = out_fill_ff;
   assign rsp_transfer_done  = out_done_ff;

endmodule

`default_nettype wire

// ===== rtl/packet_sequence_gap_tracker_top.sv =====
// ----------------------------------------------------------------------------
// packet_sequence_gap_tracker_top
// receive-side tracker of numbered packets: missing ids, byte total, done
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake          payload
//   req_ch    in          valid / ready      seq_id, payload_len
//   rsp_ch    out         valid / ready      write_offset, bytes_received,
//                                            size_error, gap_filled,
//                                            transfer_done
//   csr_ch    in          valid / ready=1    index, data
//
// an in-order, late or duplicate packet goes from lookup straight to emit; a packet
// ahead of the expected id first passes through the mark state, one skipped id per
// cycle through the single write port of the missing map.
// reset clears the tracker at once; the map needs no clearing pass.
// one item is in work at a time; a finished result waits in the output
// register while the next transaction is taken.
//
`default_nettype none

module packet_sequence_gap_tracker_top import psgt_pkg::*; #(
   parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   psgt_req_if.sink   req_ch,
   psgt_rsp_if.source rsp_ch,
   psgt_csr_if.sink   csr_ch
);

   psgt_cmd_type    cmd;
   psgt_status_type status;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   // sequencer
   psgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   psgt_dp #(
      .MAX_PACKETS (MAX_PACKETS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_seq_id         (req_ch.seq_id),
      .req_payload_len    (req_ch.payload_len),
      .csr_valid          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_write_offset   (rsp_ch.write_offset),
      .rsp_bytes_received (rsp_ch.bytes_received),
      .rsp_size_error     (rsp_ch.size_error),
      .rsp_gap_filled     (rsp_ch.gap_filled),
      .rsp_transfer_done  (rsp_ch.transfer_done)
   );

endmodule

`default_nettype wire

// ===== rtl/psgt_checker.sv =====
// ----------------------------------------------------------------------------
// psgt_checker
// port-level assertions on the gap tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_sequence_gap_tracker_top_defines.svh"

module psgt_checker import psgt_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [OFF_W-1:0] rsp_write_offset,
   input wire logic [BT_W-1:0]  rsp_bytes_received,
   input wire logic             rsp_size_error,
   input wire logic             rsp_gap_filled,
   input wire logic             rsp_transfer_done
);

   // one item in work: no transaction right after one is taken
   `PSGT_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "req taken while busy")

   // a size error is only on an in-order non-last packet, which cannot finish
   `PSGT_ASSERT_NOW(a_err_not_done, rsp_valid && rsp_size_error, !rsp_transfer_done, "size error with done")

   // a size error and a filled gap come from different id cases
   `PSGT_ASSERT_NOW(a_err_not_fill, rsp_valid && rsp_size_error, !rsp_gap_filled, "size error with gap fill")

   // a stalled result holds
   `PSGT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bytes_received) && $stable(rsp_write_offset), "stalled result changed")

endmodule

bind packet_sequence_gap_tracker_top psgt_checker u_psgt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_write_offset   (rsp_ch.write_offset),
   .rsp_bytes_received (rsp_ch.bytes_received),
   .rsp_size_error     (rsp_ch.size_error),
   .rsp_gap_filled     (rsp_ch.gap_filled),
   .rsp_transfer_done  (rsp_ch.transfer_done)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet sequence gap tracker testbench
// drives packet reports through transfer windows with reordering, drops,
// duplicates and noise, predicts every result from a shadow copy of the
// tracker state and checks each response field by field
// ----------------------------------------------------------------------------

module testbench import psgt_pkg::*; ();

   localparam int CLK_PERIOD     = 10;
   localparam int TARGET_REPORTS = 1080;
   localparam int TIMEOUT_NS     = 20_000_000;

   typedef struct {
      logic [SEQ_W-1:0] seq_id;
      logic [LEN_W-1:0] payload_len;
      bit               hold;
   } packet_report_type;

   typedef struct packed {
      logic [OFF_W-1:0] write_offset;
      logic [BT_W-1:0]  bytes_received;
      logic             size_error;
      logic             gap_filled;
      logic             transfer_done;
   } tracker_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psgt_req_if req_ch ();
   psgt_rsp_if rsp_ch ();
   psgt_csr_if csr_ch ();

   packet_sequence_gap_tracker_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow tracker state and registers
   bit               gap_map [MAX_PACKETS_DEF];
   logic [NE_W-1:0]  expected_id = '0;
   logic [CNT_W-1:0] gap_count   = '0;
   logic [BT_W-1:0]  byte_sum    = '0;
   logic [PB_W-1:0]  cfg_bytes   = PB_RESET;
   logic [PT_W-1:0]  cfg_total   = PT_RESET;

   packet_report_type  pending_packets [$];
   tracker_result_type predicted_outcomes [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int results_checked    = 0;
   int fills_seen         = 0;
   int size_errors_seen   = 0;
   int done_seen          = 0;
   int packets_queued     = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // all inputs known from time zero
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.seq_id      = '0;
      req_ch.payload_len = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;
   end

   // shadow tracker update for one packet report
   function automatic tracker_result_type track_packet(input logic [SEQ_W-1:0] seq,
                                                       input logic [LEN_W-1:0] len);
      tracker_result_type res;
      logic [BT_W:0]      sum;
      int                 id;
      res = '0;
      // late packet clears its missing mark
      if (gap_map[seq]) begin
         gap_map[seq]   = 1'b0;
         gap_count      = gap_count - 1'b1;
         res.gap_filled = 1'b1;
      end
      // saturating byte total
      sum = {1'b0, byte_sum} + (BT_W+1)'(len);
      byte_sum = sum[BT_W] ? '1 : sum[BT_W-1:0];
      if (NE_W'(seq) > expected_id) begin
         // packet ahead: mark every skipped id
         for (id = int'(expected_id); id < int'(seq); id++) begin
            if (!gap_map[id]) begin
               gap_map[id] = 1'b1;
               gap_count   = gap_count + 1'b1;
            end
         end
         expected_id = NE_W'(seq) + 1'b1;
      end else if (NE_W'(seq) == expected_id) begin
         // in order: only the last packet may be short
         expected_id = expected_id + 1'b1;
         if (len != cfg_bytes && expected_id != NE_W'(cfg_total))
            res.size_error = 1'b1;
      end
      res.transfer_done  = (expected_id == NE_W'(cfg_total)) && (gap_count == '0);
      res.write_offset   = OFF_W'(cfg_bytes) * OFF_W'(seq);
      res.bytes_received = byte_sum;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [BT_W-1:0] got,
                              input logic [BT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin : drive_reports
      packet_report_type next_pkt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predicted_outcomes.insert(predicted_outcomes.size(),
                                      track_packet(req_ch.seq_id, req_ch.payload_len));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_packets.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                !(pending_packets[0].hold && predicted_outcomes.size() != 0)) begin
               next_pkt            = pending_packets.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.seq_id      <= next_pkt.seq_id;
               req_ch.payload_len <= next_pkt.payload_len;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : check_results
      tracker_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("result transaction with no packet outstanding");
            end else begin
               want = predicted_outcomes.pop_front();
               check_field("write_offset", BT_W'(rsp_ch.write_offset),
                           BT_W'(want.write_offset));
               check_field("bytes_received", rsp_ch.bytes_received, want.bytes_received);
               check_field("size_error", BT_W'(rsp_ch.size_error), BT_W'(want.size_error));
               check_field("gap_filled", BT_W'(rsp_ch.gap_filled), BT_W'(want.gap_filled));
               check_field("transfer_done", BT_W'(rsp_ch.transfer_done),
                           BT_W'(want.transfer_done));
               results_checked++;
               fills_seen       += want.gap_filled;
               size_errors_seen += want.size_error;
               done_seen        += want.transfer_done;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic queue_packet(input int seq, input int len);
      packet_report_type pkt;
      pkt.seq_id      = SEQ_W'(seq);
      pkt.payload_len = LEN_W'(len);
      pkt.hold        = ($urandom_range(39) == 0);
      pending_packets.insert(pending_packets.size(), pkt);
      packets_queued++;
   endtask

   task automatic apply_idle_mode(input int mode);
      @(negedge clock);
      case (mode % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
         default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
   endtask

   // wait until every queued packet has its result back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_packets.size() != 0 || req_ch.valid || predicted_outcomes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      if (idx == CSR_PACKET_BYTES)
         cfg_bytes = value[PB_W-1:0];
      else if (idx == CSR_PACKET_TOTAL)
         cfg_total = value[PT_W-1:0];
      csr_ch.valid <= 1'b0;
   endtask

   // one transfer window: old gaps plus a fresh run of ids, shuffled locally
   task automatic run_window(input int window_idx);
      int                    base;
      int                    n;
      int                    total;
      int                    j;
      int                    len;
      logic [CSR_DATA_W-1:0] value;
      logic [SEQ_W-1:0]      tmp;
      logic [SEQ_W-1:0]      ids [$];
      logic [SEQ_W-1:0]      sent [$];
      base = int'(expected_id);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
      if (base + n > MAX_PACKETS_DEF)
         n = MAX_PACKETS_DEF - base;
      total = base + n;
      apply_idle_mode(window_idx);

      // packet size, extremes now and then
      case ($urandom_range(7))
         0: value = 16'd1;
         1: value = 16'hFFFF;
         2, 3: value = CSR_DATA_W'($urandom_range(1, 65535));
         default: value = CSR_DATA_W'($urandom_range(1, 64) * 64);
      endcase
      write_register(CSR_PACKET_BYTES, value);
      // transfer size, occasionally out of range; the register keeps only the low PT_W bits
      if ($urandom_range(11) == 0)
         value = $urandom_range(1) ? '0 : CSR_DATA_W'($urandom_range(4097, 65535));
      else
         value = CSR_DATA_W'(total);
      write_register(CSR_PACKET_TOTAL, value);

      // refill some earlier gaps, then the new ids
      for (int i = 0; i < base && ids.size() < 12; i++)
         if (gap_map[i])
            ids.insert(ids.size(), SEQ_W'(i));
      for (int i = base; i < total; i++)
         ids.insert(ids.size(), SEQ_W'(i));
      // last packet first forces a long gap walk
      if (n > 2 && $urandom_range(14) == 0) begin
         tmp = ids.pop_back();
         ids.push_front(tmp);
      end
      for (int i = 0; i + 1 < ids.size(); i++) begin
         if ($urandom_range(3) == 0) begin
            j = i + 1 + $urandom_range(3);
            if (j >= ids.size())
               j = ids.size() - 1;
            tmp    = ids[i];
            ids[i] = ids[j];
            ids[j] = tmp;
         end
      end
      // broken window: one packet never shows up
      if (ids.size() > 1 && $urandom_range(9) == 0)
         ids.delete($urandom_range(ids.size() - 1));

      foreach (ids[k]) begin
         if (int'(ids[k]) == total - 1 || $urandom_range(9) == 0)
            len = $urandom_range(65535);
         else
            len = int'(cfg_bytes);
         queue_packet(int'(ids[k]), len);
         sent.insert(sent.size(), ids[k]);
         if ($urandom_range(9) == 0)
            queue_packet(int'(sent[$urandom_range(sent.size() - 1)]), $urandom_range(65535));
         if (base > 0 && $urandom_range(19) == 0)
            queue_packet($urandom_range(base - 1), $urandom_range(65535));
      end
      wait_drained();
   endtask

   // stimulus sequence
   initial begin : stimulus
      int window_idx;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // in order, wrong size, ahead, late fill, duplicate, length extremes
      apply_idle_mode(0);
      queue_packet(0, 1024);
      queue_packet(1, 1000);
      queue_packet(5, 0);
      queue_packet(3, 65535);
      queue_packet(3, 7);
      queue_packet(6, 1024);
      queue_packet(2, 1024);
      queue_packet(4, 0);
      wait_drained();

      // small transfer completes, then a packet past its end
      write_register(CSR_PACKET_BYTES, 16'hFFFF);
      write_register(CSR_PACKET_TOTAL, 16'd10);
      queue_packet(9, 65535);
      queue_packet(7, 65535);
      queue_packet(8, 12);
      queue_packet(8, 3);
      queue_packet(10, 1);
      wait_drained();

      // zero total, a total beyond the map, and upper data bits dropped
      write_register(CSR_PACKET_BYTES, 16'd1);
      write_register(CSR_PACKET_TOTAL, 16'd0);
      queue_packet(11, 1);
      queue_packet(12, 0);
      wait_drained();
      write_register(CSR_PACKET_TOTAL, 16'hFFFF);
      queue_packet(13, 1);
      wait_drained();
      write_register(CSR_PACKET_TOTAL, 16'hE00F);
      queue_packet(14, 5);
      wait_drained();

      // random transfer windows
      window_idx = 0;
      while (packets_queued < TARGET_REPORTS && int'(expected_id) < MAX_PACKETS_DEF) begin
         run_window(window_idx);
         window_idx++;
      end

      // jump to the highest id, then late packets all over the map
      apply_idle_mode(2);
      write_register(CSR_PACKET_TOTAL, CSR_DATA_W'(MAX_PACKETS_DEF));
      write_register(CSR_PACKET_BYTES, CSR_DATA_W'($urandom_range(1, 65535)));
      pending_packets.insert(pending_packets.size(),
                             '{seq_id: '1, payload_len: LEN_W'($urandom_range(65535)),
                               hold: 1'b1});
      repeat (40)
         queue_packet($urandom_range(MAX_PACKETS_DEF - 1), $urandom_range(65535));
      wait_drained();

      // short run of late packets at full length
      apply_idle_mode(3);
      repeat (20)
         queue_packet($urandom_range(MAX_PACKETS_DEF - 1), 65535);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("checked %0d tracker results: %0d gap fills, %0d size errors, %0d done flags",
               results_checked, fills_seen, size_errors_seen, done_seen);
      $display("next id ended at %0d with %0d ids missing, byte total %0h",
               expected_id, gap_count, byte_sum);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", predicted_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/psgt_pkg.sv
rtl/psgt_if.sv
rtl/psgt_ram.sv
rtl/psgt_ctrl.sv
rtl/psgt_dp.sv
rtl/packet_sequence_gap_tracker_top.sv
rtl/psgt_checker.sv
verif/testbench.sv
